// ----- rtl/lfu_pkg.sv -----
// Package for the LFU key-value store: sizes, register map and the structs
// exchanged between the sequencer and the scan unit. No dependencies.
package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int KEY_W      = 31;
    localparam int VAL_W      = 31;
    localparam int CAP_W      = 5;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int USED_W     = $clog2(ENTRIES + 1);
    localparam int CMP_W      = (USED_W > CAP_W) ? USED_W : CAP_W;

    localparam int APB_DW     = 32;
    localparam int ADDR_W     = 3;
    localparam int REG_IDX_W  = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0]  REG_CAPACITY = '0;
    localparam logic [CAP_W-1:0]      CAP_RESET    = CAP_W'(16);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;

    // One entry as read out of the store during the scan
    typedef struct packed {
        logic                  vld;
        logic                  slot_valid;
        logic [IDX_W-1:0]      idx;
        logic [KEY_W-1:0]      key;
        logic [VAL_W-1:0]      value;
        logic [COUNT_BITS-1:0] count;
        logic [IDX_W-1:0]      rank;
    } lfu_entry_t;

    // Scan summary
    typedef struct packed {
        logic                  found;
        logic [IDX_W-1:0]      found_idx;
        logic [VAL_W-1:0]      found_value;
        logic [COUNT_BITS-1:0] found_count;
        logic [IDX_W-1:0]      found_rank;
        logic                  victim_vld;
        logic [IDX_W-1:0]      victim_idx;
        logic [COUNT_BITS-1:0] victim_count;
        logic [IDX_W-1:0]      victim_rank;
        logic [KEY_W-1:0]      victim_key;
        logic [USED_W-1:0]     used;
        logic                  free_vld;
        logic [IDX_W-1:0]      free_idx;
    } lfu_scan_t;

endpackage

// ----- rtl/lfu_req_if.sv -----
// Request channel of the LFU store: valid/ready plus mode, key and value.
// Depends on lfu_pkg.
interface lfu_req_if import lfu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, mode, key, value, input ready);
    modport sink   (input valid, mode, key, value, output ready);
endinterface

// ----- rtl/lfu_rsp_if.sv -----
// Response channel of the LFU store: valid/ready plus the lookup result.
// Depends on lfu_pkg.
interface lfu_rsp_if import lfu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             hit;
    logic [VAL_W-1:0] data;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;

    modport source (output valid, hit, data, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, data, evicted, evicted_key, output ready);
endinterface

// ----- rtl/lfu_cache_replacement.sv -----
// Top level of the LFU key-value store with LRU tie-break.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if and lfu_scan.
//
// Usage:
//   req carries one access per transaction: mode (0 get, 1 put), key, value.
//   rsp returns exactly one transaction per access: hit, data, evicted and
//   evicted_key. The APB port holds the capacity register at address 0.
//   An access runs from acceptance to response valid as a 16-entry
//   scan through the single read port of the entry store (one entry per
//   cycle), a drain state for the read pipeline, and an update state that
//   writes the chosen slot and renumbers the recency ranks. req.ready is high
//   only while no access is in flight, so a new access is taken only after
//   the last one has finished.
//   The response sits in an output register; a new access is accepted while
//   it waits. If rsp is still stalled when the next access finishes, the
//   update cycle holds until the register is free.
//   Reset clears all valid bits and sets capacity to 16; the store is usable
//   as soon as reset is released.
module lfu_cache_replacement import lfu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    lfu_req_if.sink             req,
    lfu_rsp_if.source           rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_UPDATE} state_t;

    state_t                state_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [CAP_W-1:0]      cap_reg;

    logic                  mode_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VAL_W-1:0]      value_reg;

    logic [KEY_W-1:0]      key_mem   [ENTRIES];
    logic [VAL_W-1:0]      value_mem [ENTRIES];
    logic [COUNT_BITS-1:0] count_mem [ENTRIES];

    logic [ENTRIES-1:0]    valid_reg;
    logic [ENTRIES-1:0]    valid_next;
    logic [IDX_W-1:0]      rank_reg  [ENTRIES];
    logic [IDX_W-1:0]      rank_next [ENTRIES];

    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_slot_vld_reg;
    logic [IDX_W-1:0]      rd_rank_reg;
    logic [KEY_W-1:0]      rd_key_reg;
    logic [VAL_W-1:0]      rd_value_reg;
    logic [COUNT_BITS-1:0] rd_count_reg;

    logic                  rsp_valid_reg;
    logic                  rsp_hit_reg;
    logic [VAL_W-1:0]      rsp_data_reg;
    logic                  rsp_evicted_reg;
    logic [KEY_W-1:0]      rsp_evicted_key_reg;

    lfu_entry_t            ent;
    lfu_scan_t             sc;
    logic                  req_fire;
    logic                  scan_clear;
    logic                  commit;
    logic [CMP_W-1:0]      cap_eff;
    logic                  full;
    logic                  do_insert;
    logic                  do_evict;
    logic                  do_fill;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [VAL_W-1:0]      wr_value;
    logic [COUNT_BITS-1:0] wr_count;
    logic                  cfg_wr;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                  && (paddr[ADDR_W-1:2] == REG_CAPACITY);
    assign prdata = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? APB_DW'(cap_reg) : '0;

    // Handshakes
    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign scan_clear = req_fire;
    assign commit     = (state_reg == S_UPDATE) && (!rsp_valid_reg || rsp.ready);

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = rsp_hit_reg;
    assign rsp.data        = rsp_data_reg;
    assign rsp.evicted     = rsp_evicted_reg;
    assign rsp.evicted_key = rsp_evicted_key_reg;

    // Scan unit
    always_comb
    begin
        ent.vld        = rd_vld_reg;
        ent.slot_valid = rd_slot_vld_reg;
        ent.idx        = rd_idx_reg;
        ent.key        = rd_key_reg;
        ent.value      = rd_value_reg;
        ent.count      = rd_count_reg;
        ent.rank       = rd_rank_reg;
    end

    lfu_scan u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (scan_clear),
        .search_key (key_reg),
        .ent        (ent),
        .res        (sc)
    );

    // Decision
    assign cap_eff   = (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                           : CMP_W'(cap_reg);
    assign full      = (CMP_W'(sc.used) >= cap_eff) && sc.victim_vld;
    assign do_insert = !sc.found && mode_reg && (cap_eff != '0);
    assign do_evict  = do_insert && full;
    assign do_fill   = do_insert && !full && sc.free_vld;
    assign wr_en     = commit && (sc.found || do_evict || do_fill);
    assign wr_idx    = sc.found ? sc.found_idx : (do_evict ? sc.victim_idx : sc.free_idx);
    assign wr_value  = (sc.found && !mode_reg) ? sc.found_value : value_reg;
    assign wr_count  = !sc.found ? COUNT_BITS'(1)
                     : ((sc.found_count == COUNT_MAX) ? sc.found_count
                                                      : sc.found_count + COUNT_BITS'(1));

    always_comb
    begin
        valid_next = valid_reg;
        for (int j = 0; j < ENTRIES; j++)
        begin
            rank_next[j] = rank_reg[j];
            if (wr_en && (wr_idx == IDX_W'(j)))
            begin
                rank_next[j]  = '0;
                valid_next[j] = 1'b1;
            end
            else if (wr_en && valid_reg[j])
            begin
                if (sc.found)
                begin
                    if (rank_reg[j] < sc.found_rank)
                    begin
                        rank_next[j] = rank_reg[j] + IDX_W'(1);
                    end
                end
                else if (do_evict)
                begin
                    if (rank_reg[j] <= sc.victim_rank)
                    begin
                        rank_next[j] = rank_reg[j] + IDX_W'(1);
                    end
                end
                else
                begin
                    rank_next[j] = rank_reg[j] + IDX_W'(1);
                end
            end
        end
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_idx]   <= key_reg;
            value_mem[wr_idx] <= wr_value;
            count_mem[wr_idx] <= wr_count;
        end
        rd_key_reg      <= key_mem[idx_reg];
        rd_value_reg    <= value_mem[idx_reg];
        rd_count_reg    <= count_mem[idx_reg];
        rd_rank_reg     <= rank_reg[idx_reg];
        rd_slot_vld_reg <= valid_reg[idx_reg];
        rd_idx_reg      <= idx_reg;
    end

    // Sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            cap_reg         <= CAP_RESET;
            valid_reg       <= '0;
            rd_vld_reg      <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                cap_reg <= pwdata[CAP_W-1:0];
            end
            valid_reg  <= valid_next;
            rd_vld_reg <= (state_reg == S_SCAN);
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (req_fire)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_W'(ENTRIES - 1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    if (commit)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ENTRIES; j++)
        begin
            rank_reg[j] <= rank_next[j];
        end
        if (req_fire)
        begin
            mode_reg  <= req.mode;
            key_reg   <= req.key;
            value_reg <= req.value;
        end
        if (commit)
        begin
            rsp_hit_reg         <= sc.found;
            rsp_data_reg        <= (sc.found && !mode_reg) ? sc.found_value : '0;
            rsp_evicted_reg     <= do_evict;
            rsp_evicted_key_reg <= do_evict ? sc.victim_key : '0;
        end
    end

    // Assertions
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while an access is in flight");

    a_occupancy_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) >= $past($countones(valid_reg)))
        else $error("stored entry lost");

    a_occupancy_step: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) <= $past($countones(valid_reg)) + 1)
        else $error("more than one entry inserted per access");

    a_rsp_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_UPDATE))
        else $error("response raised outside update");

    a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_evicted_reg && rsp_hit_reg))
        else $error("eviction reported on a hit");

endmodule

// ----- rtl/lfu_scan.sv -----
// Scan unit: takes one entry per cycle and accumulates key match, LFU/LRU
// victim, occupancy and first free slot. Depends on lfu_pkg.
module lfu_scan import lfu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic [KEY_W-1:0] search_key,
    input  lfu_entry_t       ent,
    output lfu_scan_t        res
);

    lfu_scan_t res_reg;
    lfu_scan_t res_next;
    logic      take_victim;

    assign take_victim = !res_reg.victim_vld
                       || (ent.count < res_reg.victim_count)
                       || ((ent.count == res_reg.victim_count)
                           && (ent.rank > res_reg.victim_rank));

    always_comb
    begin
        res_next = res_reg;
        if (clear)
        begin
            res_next = '0;
        end
        else if (ent.vld && ent.slot_valid)
        begin
            res_next.used = res_reg.used + USED_W'(1);
            if (ent.key == search_key)
            begin
                res_next.found       = 1'b1;
                res_next.found_idx   = ent.idx;
                res_next.found_value = ent.value;
                res_next.found_count = ent.count;
                res_next.found_rank  = ent.rank;
            end
            if (take_victim)
            begin
                res_next.victim_vld   = 1'b1;
                res_next.victim_idx   = ent.idx;
                res_next.victim_count = ent.count;
                res_next.victim_rank  = ent.rank;
                res_next.victim_key   = ent.key;
            end
        end
        else if (ent.vld && !res_reg.free_vld)
        begin
            res_next.free_vld = 1'b1;
            res_next.free_idx = ent.idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
